@@ rtl/hsbl_pkg.sv @@
// shared constants and types for the hard-stop braking limiter
`timescale 1ns / 1ps

package hsbl_pkg;

   localparam int FRAC_BITS = 16;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_UPPER_STOP  = 3'd0,
      CSR_LOWER_STOP  = 3'd1,
      CSR_STOP_MARGIN = 3'd2,
      CSR_INERTIA     = 3'd3,
      CSR_PEAK_TORQUE = 3'd4,
      CSR_GEAR_RATIO  = 3'd5
   } csr_index_type;

   // datapath widths
   localparam int E_SHIFT      = 2 * FRAC_BITS + 1;
   localparam int ENERGY_W     = 94 - E_SHIFT;
   localparam int ACC_W        = 96;
   localparam int DVS_W        = ACC_W + 1;
   localparam int DIST_STEPS   = ENERGY_W + 3 * FRAC_BITS;
   localparam int TORQUE_STEPS = ENERGY_W + FRAC_BITS;
   localparam int NUM_W        = DIST_STEPS;
   localparam int CNT_W        = $clog2(NUM_W + 1);
   localparam int TORQUE_W     = FRAC_BITS + 7;
   localparam int LIMIT_W      = 24;

   // fixed-point constants
   localparam logic [31:0]          UNITY         = 32'(1 << FRAC_BITS);
   localparam logic signed [31:0]   VEL_TEN       = 32'(10 * (1 << FRAC_BITS));
   localparam logic signed [31:0]   VEL_TEN_NEG   = 32'(-10 * (1 << FRAC_BITS));
   localparam logic [31:0]          HALF_SPEED    = 32'(1 << (FRAC_BITS - 1));
   localparam logic [63:0]          TORQUE_CAP    = 64'(100 * (1 << FRAC_BITS));
   localparam logic [TORQUE_W-1:0]  TORQUE_BRAKE  = TORQUE_W'(50 * (1 << FRAC_BITS));
   localparam logic [LIMIT_W-1:0]   LIMIT_FREE    = LIMIT_W'(100 * (1 << FRAC_BITS));
   localparam logic [LIMIT_W-1:0]   LIMIT_FREE_NEG = LIMIT_W'(-100 * (1 << FRAC_BITS));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_E_LO,
      ST_E_HI,
      ST_E_ACC,
      ST_G_LO,
      ST_G_HI,
      ST_G_ACC,
      ST_DSETUP,
      ST_DIV,
      ST_REACH,
      ST_TSETUP,
      ST_CLAMP,
      ST_DONE
   } hsbl_state_type;

endpackage

@@ rtl/hardstop_braking_limiter_core.sv @@
// hard-stop braking limiter: top level with sequencer, shared multiplier and divider
`timescale 1ns / 1ps

// One joint sample (velocity, position, signed Q16.16) enters on the req_ channel and
// exactly one result leaves on the rsp_ channel: a write flag and a 24-bit torque limit
// for each of the upper and lower side. Registers are written on the csr_ channel,
// which is always ready; write it only while no sample is in flight.
// The divider is skipped when the braking divisor or distance divisor is zero. One sample
// is worked on at a time and req_ready is low until the result has been loaded into the
// output register, so the next sample is taken only once this one's result is in the
// output register.
// The shared restoring divider gives one quotient bit per cycle: 109 steps for the
// stopping distance and 77 for the braking torque. The shared 32x32 multiplier forms
// the energy and the braking denominator, and further steps do the sums, divider setup,
// clamping and handoff.
// The result sits in an output register, so a new sample is taken while the last
// result still waits; if the receiver stalls long enough the sequencer holds in its
// last step until the output register frees.
// Reset (synchronous, active high) clears the braking flags, the held torque, the
// output valid and the registers (stops, margin and inertia to 0, peak torque and
// gear ratio to 1.0).
module hardstop_braking_limiter_core
   import hsbl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // sample channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_joint_velocity,
   input  logic signed [31:0]        req_joint_position,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_upper_limit_write,
   output logic signed [LIMIT_W-1:0] rsp_upper_limit_value,
   output logic                      rsp_lower_limit_write,
   output logic signed [LIMIT_W-1:0] rsp_lower_limit_value,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers
   logic signed [31:0] upper_stop_ff;
   logic signed [31:0] lower_stop_ff;
   logic [30:0]        margin_ff;
   logic [31:0]        inertia_ff;
   logic [31:0]        peak_ff;
   logic [31:0]        gear_ff;

   // sequencer and datapath
   hsbl_state_type     state_ff, state_in;
   logic signed [31:0] v_ff, v_in;
   logic signed [31:0] p_ff, p_in;
   logic [31:0]        av_ff, av_in;
   logic signed [32:0] du_ff, du_in;
   logic signed [32:0] dl_ff, dl_in;
   logic [32:0]        adu_ff, adu_in;
   logic [32:0]        adl_ff, adl_in;
   logic [63:0]        prod_ff, prod_in;
   logic [31:0]        hi_ff, hi_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [63:0]        quo_ff, quo_in;
   logic               sat_ff, sat_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               phase_ff, phase_in;
   logic [63:0]        reach_ff, reach_in;
   logic [TORQUE_W-1:0] torque_ff, torque_in;
   logic               hit_u_ff, hit_u_in;
   logic               hit_l_ff, hit_l_in;

   // braking state
   logic               upper_active_ff, upper_active_in;
   logic               lower_active_ff, lower_active_in;
   logic [TORQUE_W-1:0] held_ff, held_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_uw_ff, rsp_uw_in;
   logic [LIMIT_W-1:0] rsp_uval_ff, rsp_uval_in;
   logic               rsp_lw_ff, rsp_lw_in;
   logic [LIMIT_W-1:0] rsp_lval_ff, rsp_lval_in;

   // shared multiplier
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;

   // divider step
   logic [DVS_W:0]     rem_sh;
   logic [DVS_W+1:0]   diff;
   logic               fits;

   // helpers
   logic [63:0]        stop_dist;
   logic [64:0]        reach_sum;
   logic [63:0]        tq;
   logic               u_act, l_act, slow;
   logic [TORQUE_W-1:0] held_new;

   assign mul_p  = mul_a * mul_b;
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b0, dvs_ff};
   assign fits   = ~diff[DVS_W+1];

   assign stop_dist = sat_ff ? '1 : quo_ff;
   assign reach_sum = {1'b0, stop_dist} + 65'(margin_ff);
   assign tq        = sat_ff ? '1 : quo_ff;

   // commit-time braking decisions
   assign u_act    = upper_active_ff | hit_u_ff;
   assign l_act    = lower_active_ff | hit_l_ff;
   assign slow     = av_ff < HALF_SPEED;
   assign held_new = (hit_u_ff | hit_l_ff) ? torque_ff : held_ff;

   assign req_ready             = (state_ff == ST_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_upper_limit_write = rsp_uw_ff;
   assign rsp_upper_limit_value = rsp_uval_ff;
   assign rsp_lower_limit_write = rsp_lw_ff;
   assign rsp_lower_limit_value = rsp_lval_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_stop_ff <= '0;
         lower_stop_ff <= '0;
         margin_ff     <= '0;
         inertia_ff    <= '0;
         peak_ff       <= UNITY;
         gear_ff       <= UNITY;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UPPER_STOP:  upper_stop_ff <= csr_wdata;
            CSR_LOWER_STOP:  lower_stop_ff <= csr_wdata;
            CSR_STOP_MARGIN: margin_ff     <= csr_wdata[30:0];
            CSR_INERTIA:     inertia_ff    <= csr_wdata;
            CSR_PEAK_TORQUE: peak_ff       <= csr_wdata;
            CSR_GEAR_RATIO:  gear_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         upper_active_ff <= 1'b0;
         lower_active_ff <= 1'b0;
         held_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         upper_active_ff <= upper_active_in;
         lower_active_ff <= lower_active_in;
         held_ff         <= held_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      p_ff        <= p_in;
      av_ff       <= av_in;
      du_ff       <= du_in;
      dl_ff       <= dl_in;
      adu_ff      <= adu_in;
      adl_ff      <= adl_in;
      prod_ff     <= prod_in;
      hi_ff       <= hi_in;
      acc_ff      <= acc_in;
      energy_ff   <= energy_in;
      dvs_ff      <= dvs_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sat_ff      <= sat_in;
      cnt_ff      <= cnt_in;
      phase_ff    <= phase_in;
      reach_ff    <= reach_in;
      torque_ff   <= torque_in;
      hit_u_ff    <= hit_u_in;
      hit_l_ff    <= hit_l_in;
      rsp_uw_ff   <= rsp_uw_in;
      rsp_uval_ff <= rsp_uval_in;
      rsp_lw_ff   <= rsp_lw_in;
      rsp_lval_ff <= rsp_lval_in;
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in        = state_ff;
      v_in            = v_ff;
      p_in            = p_ff;
      av_in           = av_ff;
      du_in           = du_ff;
      dl_in           = dl_ff;
      adu_in          = adu_ff;
      adl_in          = adl_ff;
      prod_in         = mul_p;
      hi_in           = hi_ff;
      acc_in          = acc_ff;
      energy_in       = energy_ff;
      dvs_in          = dvs_ff;
      num_in          = num_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      sat_in          = sat_ff;
      cnt_in          = cnt_ff;
      phase_in        = phase_ff;
      reach_in        = reach_ff;
      torque_in       = torque_ff;
      hit_u_in        = hit_u_ff;
      hit_l_in        = hit_l_ff;
      upper_active_in = upper_active_ff;
      lower_active_in = lower_active_ff;
      held_in         = held_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_uw_in       = rsp_uw_ff;
      rsp_uval_in     = rsp_uval_ff;
      rsp_lw_in       = rsp_lw_ff;
      rsp_lval_in     = rsp_lval_ff;
      mul_a           = av_ff;
      mul_b           = av_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               v_in     = req_joint_velocity;
               p_in     = req_joint_position;
               av_in    = req_joint_velocity[31] ? 32'(-req_joint_velocity)
                                                 : req_joint_velocity;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            // v^2 and distances to both stops
            du_in    = {upper_stop_ff[31], upper_stop_ff} - {p_ff[31], p_ff};
            dl_in    = {lower_stop_ff[31], lower_stop_ff} - {p_ff[31], p_ff};
            state_in = ST_E_LO;
         end
         ST_E_LO: begin
            mul_a    = prod_ff[31:0];
            mul_b    = inertia_ff;
            hi_in    = prod_ff[63:32];
            adu_in   = du_ff[32] ? 33'(-du_ff) : 33'(du_ff);
            adl_in   = dl_ff[32] ? 33'(-dl_ff) : 33'(dl_ff);
            state_in = ST_E_HI;
         end
         ST_E_HI: begin
            mul_a    = hi_ff;
            mul_b    = inertia_ff;
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_E_ACC;
         end
         ST_E_ACC: begin
            mul_a    = gear_ff;
            mul_b    = gear_ff;
            acc_in   = acc_ff + {prod_ff, 32'b0};
            state_in = ST_G_LO;
         end
         ST_G_LO: begin
            energy_in = ENERGY_W'(acc_ff >> E_SHIFT);
            mul_a     = prod_ff[31:0];
            mul_b     = peak_ff;
            hi_in     = prod_ff[63:32];
            state_in  = ST_G_HI;
         end
         ST_G_HI: begin
            mul_a    = hi_ff;
            mul_b    = peak_ff;
            acc_in   = ACC_W'(prod_ff);
            state_in = ST_G_ACC;
         end
         ST_G_ACC: begin
            acc_in   = acc_ff + {prod_ff, 32'b0};
            state_in = ST_DSETUP;
         end
         ST_DSETUP: begin
            // zero denominator saturates the stopping distance
            quo_in   = '0;
            rem_in   = '0;
            phase_in = 1'b0;
            if (acc_ff == '0) begin
               sat_in   = 1'b1;
               state_in = ST_REACH;
            end else begin
               sat_in   = 1'b0;
               dvs_in   = {acc_ff, 1'b0};
               num_in   = {energy_ff, {(3 * FRAC_BITS){1'b0}}};
               cnt_in   = CNT_W'(DIST_STEPS);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            num_in = num_ff << 1;
            quo_in = {quo_ff[62:0], fits};
            sat_in = sat_ff | quo_ff[63];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = phase_ff ? ST_CLAMP : ST_REACH;
            end
         end
         ST_REACH: begin
            reach_in = reach_sum[64] ? '1 : reach_sum[63:0];
            state_in = ST_TSETUP;
         end
         ST_TSETUP: begin
            // same left-aligned dividend, fewer steps for the torque quotient
            quo_in   = '0;
            rem_in   = '0;
            sat_in   = 1'b0;
            phase_in = 1'b1;
            if (reach_ff == '0) begin
               state_in = ST_CLAMP;
            end else begin
               dvs_in   = DVS_W'(reach_ff);
               num_in   = {energy_ff, {(3 * FRAC_BITS){1'b0}}};
               cnt_in   = CNT_W'(TORQUE_STEPS);
               state_in = ST_DIV;
            end
         end
         ST_CLAMP: begin
            torque_in = (tq >= TORQUE_CAP) ? TORQUE_BRAKE : tq[TORQUE_W-1:0];
            hit_u_in  = (64'(adu_ff) <= reach_ff) && (v_ff > VEL_TEN);
            hit_l_in  = (64'(adl_ff) <= reach_ff) && (v_ff < VEL_TEN_NEG);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // wait for a free output register, then commit flags and result
            if (!rsp_valid_ff || rsp_ready) begin
               held_in         = held_new;
               upper_active_in = u_act & ~slow;
               lower_active_in = l_act & ~slow;
               rsp_valid_in    = 1'b1;
               rsp_uw_in       = u_act;
               rsp_lw_in       = l_act;
               if (!u_act) begin
                  rsp_uval_in = '0;
               end else if (slow) begin
                  rsp_uval_in = LIMIT_FREE;
               end else begin
                  rsp_uval_in = LIMIT_W'(0) - LIMIT_W'(held_new);
               end
               if (!l_act) begin
                  rsp_lval_in = '0;
               end else if (slow) begin
                  rsp_lval_in = LIMIT_FREE_NEG;
               end else begin
                  rsp_lval_in = LIMIT_W'(held_new);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/hsbl_checker.sv @@
// port-level checks for the hard-stop braking limiter, bound to the top level
`timescale 1ns / 1ps

module hsbl_checker
   import hsbl_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_upper_limit_write,
   input logic signed [LIMIT_W-1:0] rsp_upper_limit_value,
   input logic                      rsp_lower_limit_write,
   input logic signed [LIMIT_W-1:0] rsp_lower_limit_value
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one sample at a time: busy right after a transfer in
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a sample while busy");

   // a side without an update reports zero
   a_upper_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_upper_limit_write |-> rsp_upper_limit_value == '0)
      else $error("upper value without write");

   a_lower_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lower_limit_write |-> rsp_lower_limit_value == '0)
      else $error("lower value without write");

endmodule

bind hardstop_braking_limiter_core hsbl_checker u_hsbl_checker (.*);

@@ sim/tb_top.sv @@
// testbench for the hard-stop braking limiter: directed and random samples against a predictor
`timescale 1ns / 1ps

module tb_top;
   import hsbl_pkg::*;

   localparam int     ONE            = 1 << FRAC_BITS;
   localparam longint TEN_RAW        = 10 * ONE;
   localparam longint HALF_RAW       = ONE / 2;
   localparam longint HUNDRED_RAW    = 100 * ONE;
   localparam longint BRAKE_RAW      = 50 * ONE;
   localparam int     WATCHDOG_LIMIT = 5000;
   localparam int     PRESSURE_HOLD  = 800;
   localparam int     SETTLE_CYCLES  = 8;
   localparam int     END_WAIT       = 250;
   localparam int     PHASE_SAMPLES  = 125;

   typedef struct packed {
      logic               upper_write;
      logic [LIMIT_W-1:0] upper_value;
      logic               lower_write;
      logic [LIMIT_W-1:0] lower_value;
   } limit_update_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [31:0]        req_joint_velocity;
   logic signed [31:0]        req_joint_position;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_upper_limit_write;
   logic signed [LIMIT_W-1:0] rsp_upper_limit_value;
   logic                      rsp_lower_limit_write;
   logic signed [LIMIT_W-1:0] rsp_lower_limit_value;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   // register mirror and braking state of the predictor
   logic signed [31:0] cfg_upper_stop = '0;
   logic signed [31:0] cfg_lower_stop = '0;
   logic [30:0]        cfg_margin     = '0;
   logic [31:0]        cfg_inertia    = '0;
   logic [31:0]        cfg_peak       = ONE;
   logic [31:0]        cfg_gear       = ONE;
   logic               upper_engaged  = 1'b0;
   logic               lower_engaged  = 1'b0;
   logic [31:0]        held_torque    = '0;

   limit_update_type expected_limits[$];
   limit_update_type next_limit;

   int  error_count     = 0;
   int  samples_sent    = 0;
   int  results_checked = 0;
   int  limit_updates   = 0;
   int  csr_writes      = 0;
   int  config_sets     = 0;
   int  idle_cycles     = 0;

   // idling controls shared between the stimulus and the receiver
   bit  tx_gaps_on      = 1'b1;
   bit  rx_stalls_on    = 1'b1;
   int  rx_stall_left   = 0;
   int  rx_hold_left    = 0;
   int  rx_hold_request = 0;

   hardstop_braking_limiter_core u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_joint_velocity    (req_joint_velocity),
      .req_joint_position    (req_joint_position),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_upper_limit_write (rsp_upper_limit_write),
      .rsp_upper_limit_value (rsp_upper_limit_value),
      .rsp_lower_limit_write (rsp_lower_limit_write),
      .rsp_lower_limit_value (rsp_lower_limit_value),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      if (roll < 98) return $urandom_range(5, 20);
      return $urandom_range(40, 150);
   endfunction

   // floor(num * 2^shift / dvs), pinned to all ones past 64 bits
   function automatic logic [63:0] sat_quotient(logic [63:0] num, int shift,
                                                logic [127:0] dvs);
      logic [127:0] quo;
      quo = ({64'd0, num} << shift) / dvs;
      return (quo[127:64] != 0) ? '1 : quo[63:0];
   endfunction

   // energy, stopping distance and braking torque for one sample, then the flag update
   function automatic limit_update_type predict_limits(logic signed [31:0] vel,
                                                       logic signed [31:0] pos);
      logic signed [63:0] v64, p64, up64, lo64, du, dl;
      logic [63:0]        speed, energy, travel, reach, torque, adu, adl;
      logic [127:0]       prod, den;
      logic [64:0]        sum;
      limit_update_type   upd;
      v64   = 64'(vel);
      p64   = 64'(pos);
      up64  = 64'(cfg_upper_stop);
      lo64  = 64'(cfg_lower_stop);
      speed = (v64 < 0) ? -v64 : v64;

      // 0.5 * I * v^2
      prod   = 128'(speed) * 128'(speed);
      prod   = prod * 128'(cfg_inertia);
      prod   = prod >> (2 * FRAC_BITS + 1);
      energy = (prod[127:64] != 0) ? '1 : prod[63:0];

      // E / (2 * Tmax * g^2), a zero denominator means an endless distance
      den    = 128'(cfg_gear) * 128'(cfg_gear);
      den    = den * 128'(cfg_peak);
      den    = den << 1;
      travel = (den == 0) ? '1 : sat_quotient(energy, 3 * FRAC_BITS, den);

      sum   = 65'(cfg_margin) + 65'(travel);
      reach = sum[64] ? '1 : sum[63:0];

      torque = (reach == 0) ? 64'd0 : sat_quotient(energy, FRAC_BITS, {64'd0, reach});
      if (torque >= 64'(HUNDRED_RAW))
         torque = 64'(BRAKE_RAW);

      du  = up64 - p64;
      dl  = lo64 - p64;
      adu = (du < 0) ? -du : du;
      adl = (dl < 0) ? -dl : dl;

      // lower side wins the held torque when both latch
      if (adu <= reach && v64 > TEN_RAW) begin
         upper_engaged = 1'b1;
         held_torque   = torque[31:0];
      end
      if (adl <= reach && v64 < -TEN_RAW) begin
         lower_engaged = 1'b1;
         held_torque   = torque[31:0];
      end

      upd = '0;
      if (upper_engaged) begin
         upd.upper_write = 1'b1;
         if (speed < HALF_RAW) begin
            upper_engaged   = 1'b0;
            upd.upper_value = LIMIT_W'(HUNDRED_RAW);
         end else begin
            upd.upper_value = LIMIT_W'(-longint'(held_torque));
         end
      end
      if (lower_engaged) begin
         upd.lower_write = 1'b1;
         if (speed < HALF_RAW) begin
            lower_engaged   = 1'b0;
            upd.lower_value = LIMIT_W'(-HUNDRED_RAW);
         end else begin
            upd.lower_value = held_torque[LIMIT_W-1:0];
         end
      end
      return upd;
   endfunction

   // one sample transfer; valid is left high so back-to-back samples need no toggle
   task automatic send_sample(input logic signed [31:0] vel, input logic signed [31:0] pos);
      int gap;
      gap = tx_gaps_on ? random_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_joint_velocity <= vel;
      req_joint_position <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_limits.push_back(predict_limits(vel, pos));
      samples_sent++;
   endtask

   // stop offering samples and let every outstanding result come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_limits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_UPPER_STOP:  cfg_upper_stop = data;
         CSR_LOWER_STOP:  cfg_lower_stop = data;
         CSR_STOP_MARGIN: cfg_margin     = data[30:0];
         CSR_INERTIA:     cfg_inertia    = data;
         CSR_PEAK_TORQUE: cfg_peak       = data;
         CSR_GEAR_RATIO:  cfg_gear       = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers only change with the block drained
   task automatic apply_config(input logic [31:0] upper, input logic [31:0] lower,
                               input logic [31:0] margin, input logic [31:0] inertia,
                               input logic [31:0] peak, input logic [31:0] gear);
      wait_for_results();
      write_reg(CSR_UPPER_STOP, upper);
      write_reg(CSR_LOWER_STOP, lower);
      write_reg(CSR_STOP_MARGIN, margin);
      write_reg(CSR_INERTIA, inertia);
      write_reg(CSR_PEAK_TORQUE, peak);
      write_reg(CSR_GEAR_RATIO, gear);
      config_sets++;
   endtask

   // joint runs at a stop fast, slows down and usually comes to rest
   task automatic run_episode();
      longint stop_pos, pos, speed0, cur;
      int     dir, len, step;
      bit     settle;
      dir      = $urandom_range(0, 1) ? 1 : -1;
      stop_pos = (dir > 0) ? longint'(cfg_upper_stop) : longint'(cfg_lower_stop);
      len      = $urandom_range(3, 10);
      settle   = ($urandom_range(0, 4) != 0);
      speed0   = $urandom_range(11 * ONE, 60 * ONE);
      pos      = stop_pos - dir * longint'($urandom_range(0, 250 * ONE));
      for (step = 0; step < len; step++) begin
         if (settle && step == len - 1)
            cur = dir * longint'($urandom_range(0, ONE / 2 - 1));
         else
            cur = dir * (speed0 * (len - step) / len);
         send_sample(32'(cur), 32'(pos));
         pos += dir * longint'($urandom_range(0, 40 * ONE));
      end
   endtask

   // stray samples: anything at all, crawling joints, speeds around the threshold
   task automatic send_noise();
      longint mag, pos;
      int     roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         send_sample($urandom, $urandom);
      end else begin
         mag = (roll < 70) ? $urandom_range(0, ONE) : $urandom_range(0, 12 * ONE);
         pos = $urandom_range(0, 1) ? longint'(cfg_upper_stop) : longint'(cfg_lower_stop);
         pos = pos + longint'($urandom_range(0, 100 * ONE)) - 50 * ONE;
         send_sample(32'($urandom_range(0, 1) ? mag : -mag), 32'(pos));
      end
   endtask

   // reset register values: no inertia so no energy, both stops at zero
   task automatic test_reset_defaults();
      send_sample(32'sd0, 32'sd0);
      send_sample(32'h7FFF_FFFF, 32'sd0);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'sd0, 32'h7FFF_FFFF);
   endtask

   task automatic test_upper_braking();
      apply_config(100 * ONE, -100 * ONE, ONE / 2, ONE, ONE, ONE);
      send_sample(20 * ONE, -50 * ONE);
      send_sample(20 * ONE, 50 * ONE);
      send_sample(5 * ONE, 60 * ONE);
      send_sample(ONE / 4, 61 * ONE);
   endtask

   task automatic test_lower_braking();
      send_sample(-20 * ONE, -50 * ONE);
      send_sample(-ONE, -60 * ONE);
      send_sample(32'sd0, -61 * ONE);
   endtask

   // exactly 10 rad/s does not trigger, exactly 0.5 rad/s does not release
   task automatic test_velocity_thresholds();
      send_sample(10 * ONE, 90 * ONE);
      send_sample(10 * ONE + 1, 90 * ONE);
      send_sample(ONE / 2, 95 * ONE);
      send_sample(ONE / 2 - 1, 95 * ONE);
      send_sample(-10 * ONE, -90 * ONE);
      send_sample(-10 * ONE - 1, -90 * ONE);
      send_sample(-(ONE / 2) + 1, -95 * ONE);
   endtask

   // high peak torque gives a short distance and a torque above 100
   task automatic test_torque_clamp();
      apply_config(100 * ONE, -100 * ONE, ONE / 2, ONE, 100 * ONE, ONE);
      send_sample(20 * ONE, 99 * ONE);
      send_sample(32'sd0, 99 * ONE);
   endtask

   // both flags set together, the later latch decides the held torque
   task automatic test_both_sides();
      apply_config(32'd0, 32'd0, 1000 * ONE, ONE, ONE, ONE);
      send_sample(20 * ONE, 32'sd0);
      send_sample(-20 * ONE, 32'sd0);
      send_sample(32'sd0, 32'sd0);
   endtask

   // zero peak torque or gear ratio leaves the distance unbounded
   task automatic test_zero_divisors();
      apply_config(32'd0, 32'd0, 32'd0, ONE, 32'd0, ONE);
      send_sample(20 * ONE, 32'h7FFF_FFFF);
      send_sample(32'sd0, 32'sd0);
      apply_config(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, ONE, 32'd0);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'sd1, 32'sd0);
   endtask

   // receiver holds off long enough that the block fills and stalls its input
   task automatic test_output_backpressure();
      apply_config(200 * ONE, -200 * ONE, ONE, 2 * ONE, 4 * ONE, 2 * ONE);
      tx_gaps_on      = 1'b0;
      rx_hold_request = PRESSURE_HOLD;
      run_episode();
      run_episode();
      tx_gaps_on = 1'b1;
   endtask

   task automatic pick_config(input int kind);
      case (kind)
         0: apply_config($urandom_range(0, 500 * ONE), -$urandom_range(0, 500 * ONE),
                         $urandom_range(0, 5 * ONE), $urandom_range(ONE / 100, 20 * ONE),
                         $urandom_range(ONE / 2, 200 * ONE), $urandom_range(ONE / 2, 10 * ONE));
         1: apply_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         2: apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         default: apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd1, 32'd1);
      endcase
   endtask

   // phases of braking episodes mixed with stray samples under changing settings
   task automatic test_random_traffic();
      int phase, target, kind;
      for (phase = 0; phase < 12; phase++) begin
         if (phase % 4 == 3)
            kind = (phase < 6) ? 2 : 3;
         else
            kind = (phase % 4 == 1) ? 1 : 0;
         pick_config(kind);
         tx_gaps_on   = (phase % 3 != 2);
         rx_stalls_on = (phase % 3 != 2);
         target       = samples_sent + PHASE_SAMPLES;
         while (samples_sent < target) begin
            if ($urandom_range(0, 3) != 0)
               run_episode();
            else
               send_noise();
         end
      end
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   // result receiver: random stalls, plus the long hold counted here
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_request > 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
         end
         if (rx_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rx_hold_left--;
         end else if (rx_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rx_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rx_stalls_on)
               rx_stall_left = random_gap();
         end
      end
   end

   task automatic check_field(input string what, input logic [LIMIT_W-1:0] want,
                              input logic [LIMIT_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %h, got %h", $time, what, want, got);
      end
   endtask

   // every result transfer is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (rsp_upper_limit_write || rsp_lower_limit_write)
            limit_updates++;
         if (expected_limits.size() == 0) begin
            error_count++;
            $display("%0t: result with no sample outstanding, expected none, got %b %h %b %h",
                     $time, rsp_upper_limit_write, rsp_upper_limit_value,
                     rsp_lower_limit_write, rsp_lower_limit_value);
         end else begin
            next_limit = expected_limits.pop_front();
            check_field("upper_limit_write", LIMIT_W'(next_limit.upper_write),
                        LIMIT_W'(rsp_upper_limit_write));
            check_field("upper_limit_value", next_limit.upper_value, rsp_upper_limit_value);
            check_field("lower_limit_write", LIMIT_W'(next_limit.lower_write),
                        LIMIT_W'(rsp_lower_limit_write));
            check_field("lower_limit_value", next_limit.lower_value, rsp_lower_limit_value);
         end
      end
   end

   // ends the run if no transfer happens on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_limits.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_joint_velocity = '0;
      req_joint_position = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_upper_braking();
      test_lower_braking();
      test_velocity_thresholds();
      test_torque_clamp();
      test_both_sides();
      test_zero_divisors();
      test_output_backpressure();
      test_random_traffic();

      wait_for_results();
      repeat (END_WAIT) @(posedge clock);

      $display("covered %0d joint samples under %0d register settings (%0d register writes)",
               samples_sent, config_sets, csr_writes);
      $display("checked %0d results, %0d of them writing a torque limit",
               results_checked, limit_updates);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/hsbl_pkg.sv
rtl/hardstop_braking_limiter_core.sv
rtl/hsbl_checker.sv
sim/tb_top.sv
